@@ hdl/psp_pkg.sv @@
// psp_pkg: shared types, character codes and keyword tables for the
// protection string parser. no dependencies.
`default_nettype none

package psp_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7a;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5a;
    localparam logic [7:0] CH_CASE   = 8'h20;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_D      = 8'h44;

    localparam logic [2:0]  KW_LEN_MAX = 3'd7;
    localparam logic [15:0] ALL_ONES   = 16'hffff;
    localparam logic [15:0] NIBBLE     = 16'h000f;

    typedef struct packed {
        logic        hit;
        logic [1:0]  idx;
    } t_pick;

    typedef struct packed {
        logic        status;
        logic [15:0] deny_word;
        logic [15:0] keep_mask;
    } t_result;

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] f_upcase(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) ? (c - CH_CASE) : c;
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        logic [7:0] u;
        u = f_upcase(c);
        return (u >= CH_UC_A) && (u <= CH_UC_Z);
    endfunction

    // keyword letters, zero past the end of a keyword
    function automatic logic [7:0] f_kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [47:0] word;
        logic [7:0]  res;
        case (k)
            2'd0: word = {"M", "E", "T", "S", "Y", "S"};
            2'd1: word = {8'h00, "R", "E", "N", "W", "O"};
            2'd2: word = {8'h00, "P", "U", "O", "R", "G"};
            default: word = {8'h00, "D", "L", "R", "O", "W"};
        endcase
        case (idx)
            3'd0: res = word[7:0];
            3'd1: res = word[15:8];
            3'd2: res = word[23:16];
            3'd3: res = word[31:24];
            3'd4: res = word[39:32];
            3'd5: res = word[47:40];
            default: res = CH_NUL;
        endcase
        return res;
    endfunction

    // first live keyword wins
    function automatic t_pick f_pick(input logic [3:0] alive);
        t_pick p;
        p.hit = |alive;
        if (alive[0]) begin
            p.idx = 2'd0;
        end else if (alive[1]) begin
            p.idx = 2'd1;
        end else if (alive[2]) begin
            p.idx = 2'd2;
        end else begin
            p.idx = 2'd3;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hdl/protection_string_parser.sv @@
// protection_string_parser: top level, item handshake and result register
// depends on psp_pkg and psp_parser
`default_nettype none

// Feed the protection string one character per item, i_last set on the final
// one. An item is taken every cycle unless a final one is held off; the result for
// a string appears on the output in the cycle after its final character is taken,
// from a single result register. Non-final characters are taken even while a result
// is waiting; a final character is held off only while the previous result is still
// unclaimed and stalled. A syntax error returns status 1 with zero fields.
module protection_string_parser import psp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic      [15:0] o_deny_word,
    output logic      [15:0] o_keep_mask
);

    logic    take;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign o_stall = i_last && r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    psp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_ch     (i_ch),
        .i_last   (i_last),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take && i_last) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_deny_word = r_out.deny_word;
    assign o_keep_mask = r_out.keep_mask;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_last |=> o_valid)
        else $error("result not presented after final item");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_deny_word == 16'h0000) && (o_keep_mask == 16'h0000))
        else $error("error result carries nonzero fields");

    a_kept_denied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> (o_keep_mask & ~o_deny_word) == 16'h0000)
        else $error("kept field has access granted");

endmodule

`default_nettype wire

@@ hdl/psp_kw_match.sv @@
// psp_kw_match: four parallel class keyword matchers fed one letter a time
// depends on psp_pkg
`default_nettype none

module psp_kw_match import psp_pkg::*; (
    input  wire logic       i_start,
    input  wire logic [3:0] i_alive,
    input  wire logic [2:0] i_len,
    input  wire logic [7:0] i_up,
    output logic      [3:0] o_alive,
    output logic      [2:0] o_len
);

    logic [3:0] base_alive;
    logic [2:0] base_len;

    assign base_alive = i_start ? 4'hf : i_alive;
    assign base_len   = i_start ? 3'd0 : i_len;

    for (genvar k = 0; k < 4; k++) begin : g_kw
        assign o_alive[k] = base_alive[k] && (f_kw_char(2'(k), base_len) == i_up);
    end

    assign o_len = (base_len == KW_LEN_MAX) ? KW_LEN_MAX : base_len + 3'd1;

endmodule

`default_nettype wire

@@ hdl/psp_parser.sv @@
// psp_parser: parse state, class code and keep mask, updated per item
// depends on psp_pkg and psp_kw_match
`default_nettype none

module psp_parser import psp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output t_result         o_result
);

    typedef enum logic [3:0] {
        ST_PREFIX,
        ST_AFTEREQ,
        ST_OPEN,
        ST_TOP,
        ST_KEYWORD,
        ST_POSTKW,
        ST_LETWS,
        ST_LETTERS,
        ST_SEP,
        ST_CLOSE,
        ST_DONE,
        ST_ERR
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_code, n_code;
    logic [15:0] r_mask, n_mask;
    logic        r_brace, n_brace;
    logic        r_any, n_any;
    logic [3:0]  r_alive, n_alive;
    logic [2:0]  r_len, n_len;
    logic [1:0]  r_cls, n_cls;

    logic        kw_start;
    logic        kw_feed;
    logic [7:0]  up;
    logic [3:0]  m_alive;
    logic [2:0]  m_len;

    assign up = f_upcase(i_ch);

    psp_kw_match u_kw_match (
        .i_start (kw_start),
        .i_alive (r_alive),
        .i_len   (r_len),
        .i_up    (up),
        .o_alive (m_alive),
        .o_len   (m_len)
    );

    always_comb begin
        t_pick      rp;
        t_pick      fp;
        logic       sp;
        logic       letter;
        logic       eq;
        logic       rwed;
        logic [1:0] bitsel;
        t_mode      sep_to;
        logic [15:0] nib;
        logic [15:0] f_code;
        logic [15:0] f_mask;
        logic        ok;

        rp      = f_pick(r_alive);
        sp      = f_is_space(i_ch);
        letter  = f_is_letter(i_ch);
        eq      = (i_ch == CH_EQ) || (i_ch == CH_COLON);
        rwed    = (up == CH_R) || (up == CH_W) || (up == CH_E) || (up == CH_D);
        bitsel  = (up == CH_R) ? 2'd0 : (up == CH_W) ? 2'd1 : (up == CH_E) ? 2'd2 : 2'd3;
        sep_to  = (i_ch == CH_RPAREN) ? ST_CLOSE : ST_TOP;
        nib     = NIBBLE << {rp.idx, 2'b00};

        n_mode  = r_mode;
        n_code  = r_code;
        n_mask  = r_mask;
        n_brace = r_brace;
        n_any   = r_any;
        n_cls   = r_cls;
        kw_start = 1'b0;
        kw_feed  = 1'b0;

        if (r_mode != ST_DONE && r_mode != ST_ERR) begin
            if (i_ch == CH_NUL) begin
                case (r_mode)
                    ST_PREFIX, ST_AFTEREQ: n_mode = ST_ERR;
                    ST_KEYWORD: begin
                        if (rp.hit) begin
                            n_code = r_code | nib;
                            n_mask = r_mask & ~nib;
                            n_cls  = rp.idx;
                            n_any  = 1'b1;
                            n_mode = ST_DONE;
                        end else begin
                            n_mode = ST_ERR;
                        end
                    end
                    ST_CLOSE: n_mode = (r_brace && r_any) ? ST_DONE : ST_ERR;
                    default:  n_mode = ST_DONE;
                endcase
            end else begin
                case (r_mode)
                    ST_PREFIX: begin
                        if (eq) n_mode = ST_AFTEREQ;
                    end
                    ST_AFTEREQ, ST_OPEN: begin
                        if (sp) begin
                            n_mode = ST_OPEN;
                        end else if (i_ch == CH_LPAREN) begin
                            n_brace = 1'b1;
                            n_mode  = ST_TOP;
                        end else if (letter) begin
                            kw_start = 1'b1;
                            kw_feed  = 1'b1;
                            n_mode   = ST_KEYWORD;
                        end else begin
                            n_mode = sep_to;
                        end
                    end
                    ST_TOP: begin
                        if (letter) begin
                            kw_start = 1'b1;
                            kw_feed  = 1'b1;
                            n_mode   = ST_KEYWORD;
                        end else if (!sp) begin
                            n_mode = sep_to;
                        end
                    end
                    ST_KEYWORD: begin
                        if (letter) begin
                            kw_feed = 1'b1;
                        end else if (!rp.hit) begin
                            n_mode = ST_ERR;
                        end else begin
                            n_code = r_code | nib;
                            n_mask = r_mask & ~nib;
                            n_cls  = rp.idx;
                            n_any  = 1'b1;
                            if (sp) begin
                                n_mode = ST_POSTKW;
                            end else if (eq) begin
                                n_mode = ST_LETWS;
                            end else begin
                                n_mode = sep_to;
                            end
                        end
                    end
                    ST_POSTKW: begin
                        if (eq) begin
                            n_mode = ST_LETWS;
                        end else if (!sp) begin
                            n_mode = sep_to;
                        end
                    end
                    ST_LETWS, ST_LETTERS: begin
                        if (rwed) begin
                            n_code = r_code & ~(16'h0001 << {r_cls, bitsel});
                            n_mode = ST_LETTERS;
                        end else if (sp) begin
                            if (r_mode == ST_LETTERS) n_mode = ST_SEP;
                        end else begin
                            n_mode = sep_to;
                        end
                    end
                    ST_SEP: begin
                        if (!sp) n_mode = sep_to;
                    end
                    ST_CLOSE: begin
                        if (!sp) n_mode = ST_ERR;
                    end
                    default: n_mode = r_mode;
                endcase
            end
        end

        n_alive = kw_feed ? m_alive : r_alive;
        n_len   = kw_feed ? m_len : r_len;

        // outcome if the string ends here
        fp     = f_pick(n_alive);
        f_code = n_code;
        f_mask = n_mask;
        case (n_mode)
            ST_DONE: ok = 1'b1;
            ST_PREFIX, ST_AFTEREQ, ST_ERR: ok = 1'b0;
            ST_KEYWORD: begin
                ok     = fp.hit;
                f_code = n_code | (NIBBLE << {fp.idx, 2'b00});
                f_mask = n_mask & ~(NIBBLE << {fp.idx, 2'b00});
            end
            ST_CLOSE: ok = n_brace && n_any;
            default:  ok = 1'b1;
        endcase

        o_result.status    = !ok;
        o_result.deny_word = ok ? f_code : 16'h0000;
        o_result.keep_mask = ok ? f_mask : 16'h0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_mode  <= ST_PREFIX;
            r_code  <= ALL_ONES;
            r_mask  <= ALL_ONES;
            r_brace <= 1'b0;
            r_any   <= 1'b0;
            r_alive <= 4'hf;
            r_len   <= 3'd0;
            r_cls   <= 2'd0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_code  <= n_code;
            r_mask  <= n_mask;
            r_brace <= n_brace;
            r_any   <= n_any;
            r_alive <= n_alive;
            r_len   <= n_len;
            r_cls   <= n_cls;
        end
    end

endmodule

`default_nettype wire
